// File: src/sweep_range_nearest_tracker_defines.svh
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: assertion macros
// Shared macros for the concurrent assertions of the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef SWEEP_RANGE_NEAREST_TRACKER_DEFINES_SVH
`define SWEEP_RANGE_NEAREST_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SRNT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SRNT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/srnt_pkg.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: package
// Field widths, conversion constants, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srnt_pkg;

   localparam int ECHO_W     = 15;
   localparam int SLOT_W     = 7;
   localparam int SLOT_EXT_W = 8;
   localparam int ANGLE_W    = 8;
   localparam int DIST_W     = 15;
   localparam int SPEED_W    = 10;
   localparam int SUM_W      = 16;
   localparam int PROD_W     = 25;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 15;
   localparam int OUT_NEAR   = 3;

   localparam logic [SPEED_W-1:0] SOUND_SPEED_RST = 10'd343;
   localparam logic [DIST_W-1:0]  NO_ECHO_RST     = 15'd4000;

   localparam logic [CSR_IDX_W-1:0] CSR_SOUND_SPEED   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_ECHO_DIST  = 8'd1;

   // floor(p / 2000) = floor((p >> 4) / 125); 1/125 ~ 2147484 / 2^28,
   // split into an upper and a lower 11-bit half.
   localparam logic [10:0] CONV_MUL_HI = 11'd1048;
   localparam logic [10:0] CONV_MUL_LO = 11'd1180;

   // floor(s / 3) = (s * 87382) >> 18 for every 16-bit s.
   localparam logic [16:0] DIV3_MUL = 17'd87382;

   localparam logic [1:0] READS_PER_GROUP = 2'd3;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [ANGLE_W-1:0] angle;
   } tag_type;

   typedef struct packed {
      logic [ECHO_W-1:0] echo_us;
      tag_type           tag;
   } reading_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      tag_type           tag;
   } meas_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [ANGLE_W-1:0] angle;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
   } rd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      entry_type         entry;
   } wr_type;

endpackage

// File: src/srnt_if.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: channel interfaces
// Reading, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srnt_req_if;
   logic                          valid;
   logic                          ready;
   logic [srnt_pkg::ECHO_W-1:0]   echo_us;
   logic [srnt_pkg::SLOT_W-1:0]   slot;
   logic [srnt_pkg::ANGLE_W-1:0]  angle_deg;

   modport source (output valid, output echo_us, output slot, output angle_deg,
                   input ready);
   modport sink   (input valid, input echo_us, input slot, input angle_deg,
                   output ready);
endinterface

interface srnt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srnt_pkg::DIST_W-1:0]   distance_mm;
   logic [srnt_pkg::ANGLE_W-1:0]  angle_out;
   logic [srnt_pkg::DIST_W-1:0]   slot_min_distance;
   logic [srnt_pkg::ANGLE_W-1:0]  slot_min_angle;
   logic [srnt_pkg::DIST_W-1:0]   near1_distance;
   logic [srnt_pkg::ANGLE_W-1:0]  near1_angle;
   logic [srnt_pkg::DIST_W-1:0]   near2_distance;
   logic [srnt_pkg::ANGLE_W-1:0]  near2_angle;
   logic [srnt_pkg::DIST_W-1:0]   near3_distance;
   logic [srnt_pkg::ANGLE_W-1:0]  near3_angle;

   modport source (output valid, output distance_mm, output angle_out,
                   output slot_min_distance, output slot_min_angle,
                   output near1_distance, output near1_angle,
                   output near2_distance, output near2_angle,
                   output near3_distance, output near3_angle,
                   input ready);
   modport sink   (input valid, input distance_mm, input angle_out,
                   input slot_min_distance, input slot_min_angle,
                   input near1_distance, input near1_angle,
                   input near2_distance, input near2_angle,
                   input near3_distance, input near3_angle,
                   output ready);
endinterface

interface srnt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [srnt_pkg::CSR_IDX_W-1:0]   index;
   logic [srnt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/sweep_range_nearest_tracker.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: top level
// Averages ultrasonic echo readings in groups of three, keeps a per-position
// minimum table and a sorted list of the nearest returns.
// ----------------------------------------------------------------------------
// The block takes one reading transaction per clock cycle while the result
// side does not stall, and delivers one result transaction for every third
// reading. The rate is set by the per-position minimum table, a memory with
// one read and one write port: each finished group reads its entry one stage
// ahead and writes it back one stage later, and the write that lands on the
// same edge as the next read is forwarded, so a group for the same position
// need not wait for the write-back of the one before it. The table has a
// valid bit per entry that reset clears at once, so no clearing pass is
// needed and readings are accepted right after reset. Stalls on the result
// side only back up the pipeline as far as it is full. Configuration writes
// are always accepted and must be issued while no reading is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sweep_range_nearest_tracker #(
   parameter int POSITIONS = 65,
   parameter int NEAREST   = 3
) (
   input  logic        clock,
   input  logic        reset,
   srnt_req_if.sink    req_bus,
   srnt_rsp_if.source  rsp_bus,
   srnt_csr_if.sink    csr_bus
);

   localparam int DW = srnt_pkg::DIST_W;
   localparam int AW = srnt_pkg::ANGLE_W;

   logic [srnt_pkg::SPEED_W-1:0]  speed_ff;
   logic [DW-1:0]                 no_echo_ff;

   srnt_pkg::reading_type  req_item;
   srnt_pkg::meas_type     conv_item, avg_item;
   logic                   conv_valid, conv_ready;
   logic                   avg_valid, avg_ready;
   srnt_pkg::rd_type       mem_rd;
   srnt_pkg::wr_type       mem_wr;
   srnt_pkg::entry_type    cur;

   logic           fire, in_range, dist_nz, better;
   logic [DW-1:0]  meas_dist;
   logic [AW-1:0]  angle;
   logic [DW-1:0]  smin_d;
   logic [AW-1:0]  smin_a;

   logic [DW-1:0]  near_d_ff [NEAREST];
   logic [AW-1:0]  near_a_ff [NEAREST];
   logic [DW-1:0]  near_d_in [NEAREST];
   logic [AW-1:0]  near_a_in [NEAREST];
   logic [NEAREST-1:0] cond, pre;
   logic [DW-1:0]  rep_d [srnt_pkg::OUT_NEAR];
   logic [AW-1:0]  rep_a [srnt_pkg::OUT_NEAR];

   logic           rsp_valid_ff;
   logic [DW-1:0]  out_dist_ff, out_smin_d_ff;
   logic [AW-1:0]  out_angle_ff, out_smin_a_ff;
   logic [DW-1:0]  out_near_d_ff [srnt_pkg::OUT_NEAR];
   logic [AW-1:0]  out_near_a_ff [srnt_pkg::OUT_NEAR];

   // Register writes.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= srnt_pkg::SOUND_SPEED_RST;
         no_echo_ff <= srnt_pkg::NO_ECHO_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            srnt_pkg::CSR_SOUND_SPEED: begin
               speed_ff <= csr_bus.data[srnt_pkg::SPEED_W-1:0];
            end
            srnt_pkg::CSR_NO_ECHO_DIST: begin
               no_echo_ff <= csr_bus.data[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_item.echo_us   = req_bus.echo_us;
   assign req_item.tag.slot  = req_bus.slot;
   assign req_item.tag.angle = req_bus.angle_deg;

   srnt_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .sound_speed (speed_ff),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_item     (req_item),
      .out_valid   (conv_valid),
      .out_ready   (conv_ready),
      .out_item    (conv_item)
   );

   srnt_avg u_avg (
      .clock            (clock),
      .reset            (reset),
      .no_echo_distance (no_echo_ff),
      .in_valid         (conv_valid),
      .in_ready         (conv_ready),
      .in_item          (conv_item),
      .rd               (mem_rd),
      .out_valid        (avg_valid),
      .out_ready        (avg_ready),
      .out_item         (avg_item)
   );

   srnt_minmem #(
      .POSITIONS (POSITIONS)
   ) u_minmem (
      .clock (clock),
      .reset (reset),
      .rd    (mem_rd),
      .wr    (mem_wr),
      .cur   (cur)
   );

   // Update stage: table write-back, nearest list insertion, result register.
   assign avg_ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire      = avg_valid && avg_ready;
   assign meas_dist = avg_item.distance;
   assign angle     = avg_item.tag.angle;
   assign in_range  = 9'(avg_item.tag.slot) < 9'(POSITIONS);
   assign dist_nz   = (meas_dist != '0);
   assign better    = (cur.distance == '0) || (meas_dist < cur.distance);

   assign mem_wr.en             = fire && in_range && dist_nz && better;
   assign mem_wr.slot           = avg_item.tag.slot;
   assign mem_wr.entry.distance = meas_dist;
   assign mem_wr.entry.angle    = angle;

   always_comb begin
      if (!in_range) begin
         smin_d = '0;
         smin_a = '0;
      end else if (dist_nz && better) begin
         smin_d = meas_dist;
         smin_a = angle;
      end else begin
         smin_d = cur.distance;
         smin_a = cur.angle;
      end
   end

   // A nonzero new pair goes ahead of the first empty or strictly larger entry;
   // everything behind it moves down one place and the last one falls off.
   for (genvar i = 0; i < NEAREST; i++) begin : g_near
      assign cond[i] = (near_d_ff[i] == '0) || (meas_dist < near_d_ff[i]);
      if (i == 0) begin : g_head
         assign pre[i]       = cond[i];
         assign near_d_in[i] = (dist_nz && pre[i]) ? meas_dist : near_d_ff[i];
         assign near_a_in[i] = (dist_nz && pre[i]) ? angle     : near_a_ff[i];
      end else begin : g_tail
         assign pre[i]       = pre[i-1] | cond[i];
         assign near_d_in[i] = !(dist_nz && pre[i]) ? near_d_ff[i] :
                               (pre[i-1] ? near_d_ff[i-1] : meas_dist);
         assign near_a_in[i] = !(dist_nz && pre[i]) ? near_a_ff[i] :
                               (pre[i-1] ? near_a_ff[i-1] : angle);
      end
   end

   for (genvar k = 0; k < srnt_pkg::OUT_NEAR; k++) begin : g_rep
      if (k < NEAREST) begin : g_have
         assign rep_d[k] = near_d_in[k];
         assign rep_a[k] = near_a_in[k];
      end else begin : g_none
         assign rep_d[k] = '0;
         assign rep_a[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NEAREST; i++) begin
            near_d_ff[i] <= '0;
            near_a_ff[i] <= '0;
         end
      end else begin
         if (avg_ready) rsp_valid_ff <= avg_valid;
         if (fire) begin
            for (int i = 0; i < NEAREST; i++) begin
               near_d_ff[i] <= near_d_in[i];
               near_a_ff[i] <= near_a_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_dist_ff   <= meas_dist;
         out_angle_ff  <= angle;
         out_smin_d_ff <= smin_d;
         out_smin_a_ff <= smin_a;
         for (int k = 0; k < srnt_pkg::OUT_NEAR; k++) begin
            out_near_d_ff[k] <= rep_d[k];
            out_near_a_ff[k] <= rep_a[k];
         end
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.distance_mm       = out_dist_ff;
   assign rsp_bus.angle_out         = out_angle_ff;
   assign rsp_bus.slot_min_distance = out_smin_d_ff;
   assign rsp_bus.slot_min_angle    = out_smin_a_ff;
   assign rsp_bus.near1_distance    = out_near_d_ff[0];
   assign rsp_bus.near1_angle       = out_near_a_ff[0];
   assign rsp_bus.near2_distance    = out_near_d_ff[1];
   assign rsp_bus.near2_angle       = out_near_a_ff[1];
   assign rsp_bus.near3_distance    = out_near_d_ff[2];
   assign rsp_bus.near3_angle       = out_near_a_ff[2];

endmodule

// File: src/srnt_conv.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: echo conversion pipeline
// Three stages: echo times sound speed, reciprocal partial products, and the
// sum that yields floor(echo_us * sound_speed / 2000).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srnt_conv (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [srnt_pkg::SPEED_W-1:0]       sound_speed,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  srnt_pkg::reading_type              in_item,
   output logic                               out_valid,
   input  logic                               out_ready,
   output srnt_pkg::meas_type                 out_item
);

   logic                            v1_ff, v2_ff, v3_ff;
   logic                            rdy1, rdy2, rdy3;
   logic [srnt_pkg::PROD_W-1:0]     prod_ff;
   srnt_pkg::tag_type               tag1_ff, tag2_ff;
   logic [31:0]                     part_lo_ff, part_hi_ff;
   logic [20:0]                     scaled;
   logic [42:0]                     recip_sum;
   srnt_pkg::meas_type              out_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Dropping the low four bits turns the division by 2000 into one by 125.
   assign scaled    = prod_ff[srnt_pkg::PROD_W-1:4];
   assign recip_sum = {part_hi_ff, 11'b0} + 43'(part_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         prod_ff <= srnt_pkg::PROD_W'(in_item.echo_us) * srnt_pkg::PROD_W'(sound_speed);
         tag1_ff <= in_item.tag;
      end
      if (rdy2 && v1_ff) begin
         part_lo_ff <= 32'(scaled) * 32'(srnt_pkg::CONV_MUL_LO);
         part_hi_ff <= 32'(scaled) * 32'(srnt_pkg::CONV_MUL_HI);
         tag2_ff    <= tag1_ff;
      end
      if (rdy3 && v2_ff) begin
         out_ff.distance <= recip_sum[42:28];
         out_ff.tag      <= tag2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = out_ff;

endmodule

// File: src/srnt_avg.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: group averaging
// Sums three converted readings, divides the group sum by three and applies
// the no-echo substitution. Issues the table read for each finished group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srnt_avg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [srnt_pkg::DIST_W-1:0]        no_echo_distance,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  srnt_pkg::meas_type                 in_item,
   output srnt_pkg::rd_type                   rd,
   output logic                               out_valid,
   input  logic                               out_ready,
   output srnt_pkg::meas_type                 out_item
);

   logic [1:0]                    cnt_ff;
   logic [srnt_pkg::SUM_W-1:0]    sum_ff;
   logic [srnt_pkg::SUM_W-1:0]    sum_in;
   logic                          v4_ff, v5_ff;
   logic                          rdy4, rdy5;
   logic                          in_fire, group_done;
   logic [srnt_pkg::SUM_W-1:0]    group_sum_ff;
   srnt_pkg::tag_type             tag4_ff, tag5_ff;
   logic [32:0]                   div_prod_ff;
   logic [srnt_pkg::DIST_W-1:0]   quotient;

   assign rdy5       = !v5_ff || out_ready;
   assign rdy4       = !v4_ff || rdy5;
   assign in_ready   = rdy4;
   assign in_fire    = in_valid && rdy4;
   assign group_done = (cnt_ff == srnt_pkg::READS_PER_GROUP - 2'd1);
   assign sum_in     = sum_ff + srnt_pkg::SUM_W'(in_item.distance);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         sum_ff <= '0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
      end else begin
         if (in_fire) begin
            if (group_done) begin
               cnt_ff <= 2'd0;
               sum_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff + 2'd1;
               sum_ff <= sum_in;
            end
         end
         // The first two readings of a group leave a bubble behind.
         if (rdy4) v4_ff <= in_fire && group_done;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire && group_done) begin
         group_sum_ff <= sum_in;
         tag4_ff      <= in_item.tag;
      end
      if (rdy5 && v4_ff) begin
         div_prod_ff <= 33'(group_sum_ff) * 33'(srnt_pkg::DIV3_MUL);
         tag5_ff     <= tag4_ff;
      end
   end

   assign rd.en   = rdy5 && v4_ff;
   assign rd.slot = tag4_ff.slot;

   assign quotient          = div_prod_ff[32:18];
   assign out_valid         = v5_ff;
   assign out_item.distance = (quotient == '0) ? no_echo_distance : quotient;
   assign out_item.tag      = tag5_ff;

endmodule

// File: src/srnt_minmem.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: per-position minimum table
// One-read, one-write memory of (distance, angle) entries with a valid bit
// per entry and forwarding of the write that coincides with a read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srnt_minmem #(
   parameter int POSITIONS = 65
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srnt_pkg::rd_type      rd,
   input  srnt_pkg::wr_type      wr,
   output srnt_pkg::entry_type   cur
);

   localparam int IDX_W = $clog2(POSITIONS);

   srnt_pkg::entry_type                  mem [POSITIONS];
   logic [POSITIONS-1:0]                 vld_ff;
   srnt_pkg::entry_type                  rdata_ff;
   logic                                 rvld_ff;
   logic                                 fwd_hit_ff;
   srnt_pkg::entry_type                  fwd_entry_ff;
   logic [srnt_pkg::SLOT_EXT_W-1:0]      rd_ext, wr_ext;
   logic [IDX_W-1:0]                     ridx, widx;

   assign rd_ext = srnt_pkg::SLOT_EXT_W'(rd.slot);
   assign wr_ext = srnt_pkg::SLOT_EXT_W'(wr.slot);
   assign ridx   = rd_ext[IDX_W-1:0];
   assign widx   = wr_ext[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) mem[widx] <= wr.entry;
      if (rd.en) rdata_ff <= mem[ridx];
      if (rd.en) fwd_entry_ff <= wr.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rvld_ff    <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) vld_ff[widx] <= 1'b1;
         if (rd.en) begin
            rvld_ff    <= vld_ff[ridx];
            // A write at the same edge as the read is not seen by the read.
            fwd_hit_ff <= wr.en && (wr.slot == rd.slot);
         end
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         cur = fwd_entry_ff;
      end else if (rvld_ff) begin
         cur = rdata_ff;
      end else begin
         cur = '0;
      end
   end

endmodule

// File: src/srnt_checker.sv
// ----------------------------------------------------------------------------
// Sweep range nearest tracker: port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sweep_range_nearest_tracker_defines.svh"

module srnt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [srnt_pkg::DIST_W-1:0]    distance_mm,
   input logic [srnt_pkg::ANGLE_W-1:0]   angle_out,
   input logic [srnt_pkg::DIST_W-1:0]    slot_min_distance,
   input logic [srnt_pkg::DIST_W-1:0]    near1_distance,
   input logic [srnt_pkg::DIST_W-1:0]    near2_distance
);

   // A pending result stays offered until it is taken.
   `SRNT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result transaction withdrawn while stalled")

   // A stalled result keeps its distance, angle and first nearest distance.
   `SRNT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(distance_mm) && $stable(angle_out) && $stable(near1_distance), "result payload changed while stalled")

   // The nearest list is filled from the front and kept in ascending order.
   `SRNT_ASSERT_NOW(a_near_order, clock, reset, rsp_valid && (near2_distance != '0), (near1_distance != '0) && (near1_distance <= near2_distance), "nearest list out of order")

   // After an update, neither the position minimum nor the nearest entry
   // can exceed the distance that was just reported.
   `SRNT_ASSERT_NOW(a_min_bound, clock, reset, rsp_valid && (distance_mm != '0), (near1_distance != '0) && (near1_distance <= distance_mm) && (slot_min_distance <= distance_mm), "stored minimum above reported distance")

endmodule

bind sweep_range_nearest_tracker srnt_checker u_srnt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .distance_mm       (rsp_bus.distance_mm),
   .angle_out         (rsp_bus.angle_out),
   .slot_min_distance (rsp_bus.slot_min_distance),
   .near1_distance    (rsp_bus.near1_distance),
   .near2_distance    (rsp_bus.near2_distance)
);
